@@ hdl/set_assoc_writeback_cache_defines.svh @@
// assertion macros for the set-associative write-back cache
`ifndef SET_ASSOC_WRITEBACK_CACHE_DEFINES_SVH
`define SET_ASSOC_WRITEBACK_CACHE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ck, rn, ante, cons)
`define ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

@@ hdl/sawbc_pkg.sv @@
// shared constants, types and helpers for the write-back cache
`timescale 1ns / 1ps
`default_nettype none
package sawbc_pkg;

    localparam int SETS       = 4;
    localparam int WAYS       = 2;
    localparam int LINE_WORDS = 4;
    localparam int NLINES     = SETS * WAYS;
    localparam int WORD_W     = $clog2(LINE_WORDS);
    localparam int SET_W      = $clog2(SETS);
    localparam int WAY_W      = $clog2(WAYS);
    localparam int LINE_W     = SET_W + WAY_W;
    localparam int TAG_W      = 30 - SET_W - WORD_W;
    localparam int RANK_W     = WAY_W;
    localparam int MEM_AW     = LINE_W + WORD_W;
    localparam int MEM_DEPTH  = NLINES * LINE_WORDS;

    localparam logic CFG_HIT_LATENCY  = 1'b0;
    localparam logic CFG_MISS_LATENCY = 1'b1;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FLUSH = 2'd2,
        OP_FILL  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_RDATA      = 3'd0,
        KIND_WRITE_DONE = 3'd1,
        KIND_WRITE_BACK = 3'd2,
        KIND_FILL_REQ   = 3'd3,
        KIND_FLUSH_DONE = 3'd4,
        KIND_ERROR      = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ERR,
        S_WB_RD,
        S_WB_OUT,
        S_MISS_UPD,
        S_FILL_REQ,
        S_FIN,
        S_FIN_OUT,
        S_FL_RD,
        S_FL_WAY,
        S_FL_NEXT,
        S_FL_DONE
    } state_t;

    typedef struct packed {
        logic  accept;
        logic  fill_write;
        logic  fin_from_pend;
        logic  lookup_hit;
        logic  lookup_miss;
        logic  miss_update;
        logic  fin_exec;
        logic  wb_read;
        logic  cnt_inc;
        logic  cnt_clear;
        logic  fl_init;
        logic  fl_read;
        logic  fl_wb_start;
        logic  fl_next_way;
        logic  fl_next_set;
        logic  fl_clear;
        logic  emit;
        kind_t emit_kind;
        logic  emit_last;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic pend_valid;
        logic fill_last;
        logic hit_found;
        logic victim_dirty;
        logic word_last;
        logic fl_dirty;
        logic way_last;
        logic set_last;
        logic fin_write;
        logic out_free;
    } status_t;

    function automatic logic [LINE_W-1:0] line_of(input logic [SET_W-1:0] s,
                                                  input logic [WAY_W-1:0] w);
        return {s, w};
    endfunction

endpackage
`default_nettype wire

@@ hdl/sawbc_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module sawbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/sawbc_ctrl.sv @@
// controller state machine for the write-back cache
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_writeback_cache_defines.svh"
module sawbc_ctrl
    import sawbc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire status_t st,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   dec_fill_last;
    logic   fin_out_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (st.pend_valid)
                begin
                    if (st.op != OP_FILL)
                    begin
                        state_next = S_ERR;
                    end
                    else if (st.fill_last)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (st.op == OP_FILL)
                begin
                    state_next = S_ERR;
                end
                else if (st.op == OP_FLUSH)
                begin
                    state_next = S_FL_RD;
                end
                else if (st.hit_found)
                begin
                    state_next = S_FIN;
                end
                else if (st.victim_dirty)
                begin
                    state_next = S_WB_RD;
                end
                else
                begin
                    state_next = S_MISS_UPD;
                end
            end
            S_ERR:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WB_RD:
            begin
                state_next = S_WB_OUT;
            end
            S_WB_OUT:
            begin
                if (st.out_free)
                begin
                    if (!st.word_last)
                    begin
                        state_next = S_WB_RD;
                    end
                    else if (st.op == OP_FLUSH)
                    begin
                        state_next = S_FL_NEXT;
                    end
                    else
                    begin
                        state_next = S_MISS_UPD;
                    end
                end
            end
            S_MISS_UPD:
            begin
                state_next = S_FILL_REQ;
            end
            S_FILL_REQ:
            begin
                if (st.out_free && st.word_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                state_next = S_FIN_OUT;
            end
            S_FIN_OUT:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FL_RD:
            begin
                state_next = S_FL_WAY;
            end
            S_FL_WAY:
            begin
                state_next = st.fl_dirty ? S_WB_RD : S_FL_NEXT;
            end
            S_FL_NEXT:
            begin
                if (!st.way_last)
                begin
                    state_next = S_FL_WAY;
                end
                else if (st.set_last)
                begin
                    state_next = S_FL_DONE;
                end
                else
                begin
                    state_next = S_FL_RD;
                end
            end
            S_FL_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.emit_kind = KIND_RDATA;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
            end
            S_DECODE:
            begin
                if (st.pend_valid)
                begin
                    if (st.op == OP_FILL)
                    begin
                        cmd.fill_write    = 1'b1;
                        cmd.fin_from_pend = st.fill_last;
                    end
                end
                else if (st.op == OP_FLUSH)
                begin
                    cmd.fl_init = 1'b1;
                end
                else if (st.op != OP_FILL)
                begin
                    cmd.lookup_hit  = st.hit_found;
                    cmd.lookup_miss = !st.hit_found;
                end
            end
            S_ERR:
            begin
                cmd.emit      = st.out_free;
                cmd.emit_kind = KIND_ERROR;
                cmd.emit_last = 1'b1;
            end
            S_WB_RD:
            begin
                cmd.wb_read = 1'b1;
            end
            S_WB_OUT:
            begin
                cmd.emit      = st.out_free;
                cmd.emit_kind = KIND_WRITE_BACK;
                cmd.cnt_inc   = st.out_free && !st.word_last;
                cmd.cnt_clear = st.out_free && st.word_last;
            end
            S_MISS_UPD:
            begin
                cmd.miss_update = 1'b1;
            end
            S_FILL_REQ:
            begin
                cmd.emit      = st.out_free;
                cmd.emit_kind = KIND_FILL_REQ;
                cmd.emit_last = st.word_last;
                cmd.cnt_inc   = st.out_free && !st.word_last;
                cmd.cnt_clear = st.out_free && st.word_last;
            end
            S_FIN:
            begin
                cmd.fin_exec = 1'b1;
            end
            S_FIN_OUT:
            begin
                cmd.emit      = st.out_free;
                cmd.emit_kind = st.fin_write ? KIND_WRITE_DONE : KIND_RDATA;
                cmd.emit_last = 1'b1;
            end
            S_FL_RD:
            begin
                cmd.fl_read = 1'b1;
            end
            S_FL_WAY:
            begin
                cmd.fl_wb_start = st.fl_dirty;
            end
            S_FL_NEXT:
            begin
                cmd.fl_next_way = !st.way_last;
                cmd.fl_next_set = st.way_last && !st.set_last;
            end
            S_FL_DONE:
            begin
                cmd.emit      = st.out_free;
                cmd.emit_kind = KIND_FLUSH_DONE;
                cmd.emit_last = 1'b1;
                cmd.fl_clear  = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign dec_fill_last = (state_reg == S_DECODE) && st.pend_valid && (st.op == OP_FILL)
                           && st.fill_last;
    assign fin_out_emit  = (state_reg == S_FIN_OUT) && cmd.emit;

    `ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, st.out_free)
    `ASSERT_NXT(a_fill_done_fin, clk, rst_n, dec_fill_last, state_reg == S_FIN)
    `ASSERT_NXT(a_fin_out_idle, clk, rst_n, fin_out_emit, state_reg == S_IDLE)
    `ASSERT_NXT(a_wb_pair, clk, rst_n, state_reg == S_WB_RD, state_reg == S_WB_OUT)

endmodule
`default_nettype wire

@@ hdl/sawbc_dp.sv @@
// datapath: line state, tag and word storage, counters, result register
`timescale 1ns / 1ps
`default_nettype none
module sawbc_dp
    import sawbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output status_t          st,
    input  wire logic [1:0]  op,
    input  wire logic [31:0] addr,
    input  wire logic [31:0] wdata,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [31:0]      next_addr,
    output logic [31:0]      rdata,
    output logic             hit,
    output logic [31:0]      model_time,
    output logic [31:0]      miss_total,
    output logic             last,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [15:0]             hit_lat_reg;
    logic [15:0]             miss_lat_reg;
    logic [1:0]              op_reg;
    logic [31:0]             addr_reg;
    logic [31:0]             data_reg;
    logic [NLINES-1:0]       valid_reg;
    logic [NLINES-1:0]       valid_next;
    logic [NLINES-1:0]       dirty_reg;
    logic [NLINES-1:0]       dirty_next;
    logic [RANK_W-1:0]       rank_reg [NLINES];
    logic [RANK_W-1:0]       rank_next [NLINES];
    logic [31:0]             time_reg;
    logic [31:0]             read_total_reg;
    logic [31:0]             write_total_reg;
    logic [31:0]             miss_count_reg;
    logic                    pend_valid_reg;
    logic                    pend_write_reg;
    logic [WORD_W-1:0]       pend_word_reg;
    logic [31:0]             pend_data_reg;
    logic [LINE_W-1:0]       pend_line_reg;
    logic [WORD_W-1:0]       fill_idx_reg;
    logic                    fin_write_reg;
    logic [WORD_W-1:0]       fin_word_reg;
    logic [31:0]             fin_data_reg;
    logic [LINE_W-1:0]       fin_line_reg;
    logic                    hit_reg;
    logic [WAY_W-1:0]        victim_reg;
    logic [LINE_W-1:0]       wb_line_reg;
    logic [TAG_W-1:0]        wb_tag_reg;
    logic [WORD_W-1:0]       cnt_reg;
    logic [SET_W-1:0]        set_cnt_reg;
    logic [WAY_W-1:0]        way_cnt_reg;
    logic                    out_valid_reg;

    logic [SET_W-1:0]        req_set;
    logic [TAG_W-1:0]        req_tag;
    logic [WORD_W-1:0]       req_word;
    logic                    hit_found;
    logic [WAY_W-1:0]        hit_way;
    logic [WAY_W-1:0]        vic_way;
    logic                    found_inv;
    logic [LINE_W-1:0]       vic_line;
    logic [LINE_W-1:0]       fl_line;
    logic                    out_free;

    logic                    t_we;
    logic [SET_W-1:0]        t_waddr;
    logic [WAYS*TAG_W-1:0]   t_wdata;
    logic                    t_re;
    logic [SET_W-1:0]        t_raddr;
    logic [WAYS*TAG_W-1:0]   t_q;
    logic                    w_we;
    logic [MEM_AW-1:0]       w_waddr;
    logic [31:0]             w_wdata;
    logic                    w_re;
    logic [MEM_AW-1:0]       w_raddr;
    logic [31:0]             w_q;

    assign req_set  = addr_reg[2+WORD_W +: SET_W];
    assign req_tag  = addr_reg[31 -: TAG_W];
    assign req_word = addr_reg[2 +: WORD_W];
    assign vic_line = line_of(req_set, vic_way);
    assign fl_line  = line_of(set_cnt_reg, way_cnt_reg);
    assign out_free = !out_valid_reg || !out_stall;

    sawbc_ram #(.WIDTH(WAYS*TAG_W), .DEPTH(SETS)) u_tag_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .re    (t_re),
        .raddr (t_raddr),
        .rdata (t_q)
    );

    sawbc_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_word_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .re    (w_re),
        .raddr (w_raddr),
        .rdata (w_q)
    );

    // tag compare and victim choice
    always_comb
    begin
        hit_found = 1'b0;
        hit_way   = '0;
        found_inv = 1'b0;
        vic_way   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_found && valid_reg[line_of(req_set, WAY_W'(w))]
                && t_q[w*TAG_W +: TAG_W] == req_tag)
            begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
            if (!found_inv && !valid_reg[line_of(req_set, WAY_W'(w))])
            begin
                found_inv = 1'b1;
                vic_way   = WAY_W'(w);
            end
        end
        if (!found_inv)
        begin
            for (int w = 1; w < WAYS; w++)
            begin
                if (rank_reg[line_of(req_set, WAY_W'(w))]
                    > rank_reg[line_of(req_set, vic_way)])
                begin
                    vic_way = WAY_W'(w);
                end
            end
        end
    end

    always_comb
    begin
        st.op           = op_t'(op_reg);
        st.pend_valid   = pend_valid_reg;
        st.fill_last    = (fill_idx_reg == WORD_W'(LINE_WORDS - 1));
        st.hit_found    = hit_found;
        st.victim_dirty = valid_reg[vic_line] && dirty_reg[vic_line];
        st.word_last    = (cnt_reg == WORD_W'(LINE_WORDS - 1));
        st.fl_dirty     = valid_reg[fl_line] && dirty_reg[fl_line];
        st.way_last     = (way_cnt_reg == WAY_W'(WAYS - 1));
        st.set_last     = (set_cnt_reg == SET_W'(SETS - 1));
        st.fin_write    = fin_write_reg;
        st.out_free     = out_free;
    end

    // storage ports
    always_comb
    begin
        t_we    = cmd.miss_update;
        t_waddr = req_set;
        t_wdata = t_q;
        t_wdata[victim_reg*TAG_W +: TAG_W] = req_tag;
        t_re    = cmd.accept || cmd.fl_read;
        t_raddr = cmd.accept ? addr[2+WORD_W +: SET_W] : set_cnt_reg;

        w_we    = 1'b0;
        w_waddr = {pend_line_reg, fill_idx_reg};
        w_wdata = data_reg;
        w_re    = 1'b0;
        w_raddr = {wb_line_reg, cnt_reg};
        if (cmd.fill_write)
        begin
            w_we = 1'b1;
        end
        if (cmd.fin_exec)
        begin
            if (fin_write_reg)
            begin
                w_we    = 1'b1;
                w_waddr = {fin_line_reg, fin_word_reg};
                w_wdata = fin_data_reg;
            end
            else
            begin
                w_re    = 1'b1;
                w_raddr = {fin_line_reg, fin_word_reg};
            end
        end
        if (cmd.wb_read)
        begin
            w_re = 1'b1;
        end
    end

    // line flags and recency ranks
    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        rank_next  = rank_reg;
        if (cmd.miss_update)
        begin
            valid_next[line_of(req_set, victim_reg)] = 1'b1;
            dirty_next[line_of(req_set, victim_reg)] = 1'b0;
        end
        if (cmd.fin_exec)
        begin
            if (fin_write_reg)
            begin
                dirty_next[fin_line_reg] = 1'b1;
            end
            for (int w = 0; w < WAYS; w++)
            begin
                if (WAY_W'(w) == fin_line_reg[WAY_W-1:0])
                begin
                    rank_next[line_of(fin_line_reg[LINE_W-1:WAY_W], WAY_W'(w))] = '0;
                end
                else if (rank_reg[line_of(fin_line_reg[LINE_W-1:WAY_W], WAY_W'(w))]
                         <= rank_reg[fin_line_reg]
                         && rank_reg[line_of(fin_line_reg[LINE_W-1:WAY_W], WAY_W'(w))]
                         < RANK_W'(WAYS - 1))
                begin
                    rank_next[line_of(fin_line_reg[LINE_W-1:WAY_W], WAY_W'(w))] =
                        rank_reg[line_of(fin_line_reg[LINE_W-1:WAY_W], WAY_W'(w))]
                        + RANK_W'(1);
                end
            end
        end
        if (cmd.fl_clear)
        begin
            valid_next = '0;
            dirty_next = '0;
            for (int i = 0; i < NLINES; i++)
            begin
                rank_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_lat_reg     <= 16'd1;
            miss_lat_reg    <= 16'd1;
            valid_reg       <= '0;
            dirty_reg       <= '0;
            for (int i = 0; i < NLINES; i++)
            begin
                rank_reg[i] <= '0;
            end
            time_reg        <= '0;
            read_total_reg  <= '0;
            write_total_reg <= '0;
            miss_count_reg  <= '0;
            pend_valid_reg  <= 1'b0;
            fill_idx_reg    <= '0;
            cnt_reg         <= '0;
            set_cnt_reg     <= '0;
            way_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_HIT_LATENCY)
                begin
                    hit_lat_reg <= cfg_data;
                end
                else
                begin
                    miss_lat_reg <= cfg_data;
                end
            end
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            rank_reg  <= rank_next;
            if (cmd.lookup_hit || cmd.lookup_miss)
            begin
                if (op_reg == OP_READ)
                begin
                    read_total_reg <= read_total_reg + 32'd1;
                end
                else
                begin
                    write_total_reg <= write_total_reg + 32'd1;
                end
            end
            if (cmd.lookup_hit)
            begin
                time_reg <= time_reg + 32'(hit_lat_reg);
            end
            if (cmd.lookup_miss)
            begin
                time_reg       <= time_reg + 32'(miss_lat_reg);
                miss_count_reg <= miss_count_reg + 32'd1;
            end
            if (cmd.miss_update)
            begin
                pend_valid_reg <= 1'b1;
                fill_idx_reg   <= '0;
            end
            if (cmd.fin_from_pend)
            begin
                pend_valid_reg <= 1'b0;
                fill_idx_reg   <= '0;
            end
            else if (cmd.fill_write)
            begin
                fill_idx_reg <= fill_idx_reg + WORD_W'(1);
            end
            if (cmd.cnt_clear)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + WORD_W'(1);
            end
            if (cmd.fl_init)
            begin
                set_cnt_reg <= '0;
            end
            else if (cmd.fl_next_set)
            begin
                set_cnt_reg <= set_cnt_reg + SET_W'(1);
            end
            if (cmd.fl_read)
            begin
                way_cnt_reg <= '0;
            end
            else if (cmd.fl_next_way)
            begin
                way_cnt_reg <= way_cnt_reg + WAY_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= op;
            addr_reg <= addr;
            data_reg <= wdata;
        end
        if (cmd.lookup_hit)
        begin
            fin_write_reg <= (op_reg == OP_WRITE);
            fin_word_reg  <= req_word;
            fin_data_reg  <= data_reg;
            fin_line_reg  <= line_of(req_set, hit_way);
            hit_reg       <= 1'b1;
        end
        if (cmd.lookup_miss)
        begin
            victim_reg  <= vic_way;
            wb_line_reg <= vic_line;
            wb_tag_reg  <= t_q[vic_way*TAG_W +: TAG_W];
        end
        if (cmd.miss_update)
        begin
            pend_write_reg <= (op_reg == OP_WRITE);
            pend_word_reg  <= req_word;
            pend_data_reg  <= data_reg;
            pend_line_reg  <= line_of(req_set, victim_reg);
        end
        if (cmd.fin_from_pend)
        begin
            fin_write_reg <= pend_write_reg;
            fin_word_reg  <= pend_word_reg;
            fin_data_reg  <= pend_data_reg;
            fin_line_reg  <= pend_line_reg;
            hit_reg       <= 1'b0;
        end
        if (cmd.fl_wb_start)
        begin
            wb_line_reg <= fl_line;
            wb_tag_reg  <= t_q[way_cnt_reg*TAG_W +: TAG_W];
        end
        if (cmd.emit)
        begin
            kind       <= cmd.emit_kind;
            model_time <= time_reg;
            miss_total <= miss_count_reg;
            last       <= cmd.emit_last;
            case (cmd.emit_kind)
                KIND_WRITE_BACK:
                begin
                    next_addr <= {wb_tag_reg, wb_line_reg[LINE_W-1:WAY_W], cnt_reg, 2'b00};
                    rdata     <= w_q;
                    hit       <= 1'b0;
                end
                KIND_FILL_REQ:
                begin
                    next_addr <= {req_tag, req_set, cnt_reg, 2'b00};
                    rdata     <= '0;
                    hit       <= 1'b0;
                end
                KIND_RDATA:
                begin
                    next_addr <= '0;
                    rdata     <= w_q;
                    hit       <= hit_reg;
                end
                KIND_WRITE_DONE:
                begin
                    next_addr <= '0;
                    rdata     <= '0;
                    hit       <= hit_reg;
                end
                default:
                begin
                    next_addr <= '0;
                    rdata     <= '0;
                    hit       <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

@@ hdl/set_assoc_writeback_cache.sv @@
// top level of the set-associative write-back cache
`timescale 1ns / 1ps
`default_nettype none
// Four sets of two ways, four 32-bit words a line, write-allocate, write-back, LRU.
// One request is handled at a time. A hit goes through accept, tag read and compare,
// word access and result register. A miss emits one fill request a cycle while the
// result side does not stall, after a word read and an output step per written-back
// word of a dirty victim; each returned fill word is accepted, then written, and the
// last one adds a word access and a result step. A flush reads the tags of each set,
// visits each way and writes back every word of a dirty line. The single word RAM
// port and the single result register pace these steps. Results leave through a
// register, so a new request can be taken while an earlier result still waits.
module set_assoc_writeback_cache
    import sawbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [31:0] addr,
    input  wire logic [31:0] wdata,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [31:0]      next_addr,
    output logic [31:0]      rdata,
    output logic             hit,
    output logic [31:0]      model_time,
    output logic [31:0]      miss_total,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    sawbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    sawbc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .op         (op),
        .addr       (addr),
        .wdata      (wdata),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .next_addr  (next_addr),
        .rdata      (rdata),
        .hit        (hit),
        .model_time (model_time),
        .miss_total (miss_total),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

endmodule
`default_nettype wire

@@ tb/sv/sawbc_checker.sv @@
// request/result checker for the write-back cache: predicts every result and compares it
`timescale 1ns / 1ps
module sawbc_checker
    import sawbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  op,
    input  logic [31:0] addr,
    input  logic [31:0] wdata,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] next_addr,
    input  logic [31:0] rdata,
    input  logic        hit,
    input  logic [31:0] model_time,
    input  logic [31:0] miss_total,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          outstanding
);

    typedef struct {
        kind_t       kind;
        logic [31:0] next_addr;
        logic [31:0] rdata;
        logic        hit;
        logic [31:0] model_time;
        logic [31:0] miss_total;
        logic        last;
    } result_t;

    result_t     exp_results[$];

    logic        line_ok[NLINES];
    logic        line_mod[NLINES];
    logic [TAG_W-1:0] line_tag[NLINES];
    logic [31:0] line_data[NLINES][LINE_WORDS];
    int unsigned line_rank[NLINES];
    logic [31:0] now;
    logic [31:0] misses;
    logic [15:0] hit_lat = 16'd1;
    logic [15:0] miss_lat = 16'd1;
    logic        fill_open = 1'b0;
    op_t         fill_op;
    logic [31:0] fill_addr;
    logic [31:0] fill_data;
    int          fill_line;
    int          fill_pos = 0;

    initial
    begin
        errors = 0;
        outstanding = 0;
        now = '0;
        misses = '0;
        for (int i = 0; i < NLINES; i++)
        begin
            line_ok[i] = 1'b0;
            line_mod[i] = 1'b0;
            line_rank[i] = 0;
        end
    end

    task automatic push(kind_t k, logic [31:0] na, logic [31:0] rd, logic h);
        result_t r;
        r.kind = k;
        r.next_addr = na;
        r.rdata = rd;
        r.hit = h;
        r.model_time = now;
        r.miss_total = misses;
        r.last = 1'b0;
        exp_results.push_back(r);
    endtask

    function automatic logic [31:0] line_address(logic [TAG_W-1:0] t, int s, int j);
        logic [SET_W-1:0]  sv;
        logic [WORD_W-1:0] jv;
        sv = s[SET_W-1:0];
        jv = j[WORD_W-1:0];
        return {t, sv, jv, 2'b00};
    endfunction

    task automatic promote(int s, int way);
        int b;
        int unsigned old;
        b = s * WAYS;
        old = line_rank[b + way];
        for (int w = 0; w < WAYS; w++)
            if (w != way && line_rank[b + w] <= old && line_rank[b + w] < WAYS - 1)
                line_rank[b + w]++;
        line_rank[b + way] = 0;
    endtask

    task automatic evict_words(int li);
        for (int j = 0; j < LINE_WORDS; j++)
            push(KIND_WRITE_BACK, line_address(line_tag[li], li / WAYS, j), line_data[li][j], 1'b0);
    endtask

    task automatic complete(op_t o, logic [31:0] a, logic [31:0] d, int li, logic h);
        int wi;
        wi = a[WORD_W+1:2];
        promote(li / WAYS, li % WAYS);
        if (o == OP_READ)
            push(KIND_RDATA, '0, line_data[li][wi], h);
        else
        begin
            line_data[li][wi] = d;
            line_mod[li] = 1'b1;
            push(KIND_WRITE_DONE, '0, '0, h);
        end
    endtask

    task automatic predict(op_t o, logic [31:0] a, logic [31:0] d);
        int n0;
        int s;
        int b;
        int w;
        int victim;
        logic [TAG_W-1:0] t;
        n0 = exp_results.size();
        if (fill_open)
        begin
            if (o != OP_FILL)
                push(KIND_ERROR, '0, '0, 1'b0);
            else
            begin
                line_data[fill_line][fill_pos] = d;
                fill_pos++;
                if (fill_pos == LINE_WORDS)
                begin
                    fill_open = 1'b0;
                    fill_pos = 0;
                    complete(fill_op, fill_addr, fill_data, fill_line, 1'b0);
                end
            end
        end
        else if (o == OP_FILL)
            push(KIND_ERROR, '0, '0, 1'b0);
        else if (o == OP_FLUSH)
        begin
            for (int li = 0; li < NLINES; li++)
            begin
                if (line_ok[li] && line_mod[li])
                    evict_words(li);
                line_ok[li] = 1'b0;
                line_mod[li] = 1'b0;
                line_rank[li] = 0;
            end
            push(KIND_FLUSH_DONE, '0, '0, 1'b0);
        end
        else
        begin
            s = a[SET_W+WORD_W+1:WORD_W+2];
            t = a[31:SET_W+WORD_W+2];
            b = s * WAYS;
            for (w = 0; w < WAYS; w++)
                if (line_ok[b + w] && line_tag[b + w] == t)
                    break;
            if (w < WAYS)
            begin
                now += hit_lat;
                complete(o, a, d, b + w, 1'b1);
            end
            else
            begin
                now += miss_lat;
                misses++;
                victim = -1;
                for (w = 0; w < WAYS; w++)
                    if (!line_ok[b + w] && victim < 0)
                        victim = w;
                if (victim < 0)
                begin
                    victim = 0;
                    for (w = 1; w < WAYS; w++)
                        if (line_rank[b + w] > line_rank[b + victim])
                            victim = w;
                end
                if (line_ok[b + victim] && line_mod[b + victim])
                    evict_words(b + victim);
                line_ok[b + victim] = 1'b1;
                line_mod[b + victim] = 1'b0;
                line_tag[b + victim] = t;
                for (int j = 0; j < LINE_WORDS; j++)
                    push(KIND_FILL_REQ, line_address(t, s, j), '0, 1'b0);
                fill_open = 1'b1;
                fill_op = o;
                fill_addr = a;
                fill_data = d;
                fill_line = b + victim;
                fill_pos = 0;
            end
        end
        if (exp_results.size() > n0)
            exp_results[exp_results.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
        if (actv !== expv)
        begin
            $error("%s mismatch: expected %h, got %h", name, expv, actv);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t r;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_HIT_LATENCY)
                    hit_lat = cfg_data;
                else
                    miss_lat = cfg_data;
            end
            if (in_valid && !in_stall)
                predict(op_t'(op), addr, wdata);
            if (out_valid && !out_stall)
            begin
                if (exp_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d addr %h data %h", kind, next_addr, rdata);
                    errors++;
                end
                else
                begin
                    r = exp_results.pop_front();
                    check_field("kind", 32'(r.kind), 32'(kind));
                    check_field("next_addr", r.next_addr, next_addr);
                    check_field("rdata", r.rdata, rdata);
                    check_field("hit", 32'(r.hit), 32'(hit));
                    check_field("model_time", r.model_time, model_time);
                    check_field("miss_total", r.miss_total, miss_total);
                    check_field("last", 32'(r.last), 32'(last));
                end
            end
            outstanding = exp_results.size();
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
// testbench top for the write-back cache: request stimulus, config phases and verdict
`timescale 1ns / 1ps
module tb_top;
    import sawbc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = '0;
    logic [31:0] addr = '0;
    logic [31:0] wdata = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [31:0] next_addr;
    logic [31:0] rdata;
    logic        hit;
    logic [31:0] model_time;
    logic [31:0] miss_total;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_HIT_LATENCY;
    logic [15:0] cfg_data = '0;
    int          errors;
    int          outstanding;

    int          done_count = 0;
    int          fill_req_count = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;

    localparam int WATCHDOG_LIMIT = 20000;

    always #5 clk = ~clk;

    set_assoc_writeback_cache dut (.*);

    sawbc_checker u_checker (.*);

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (last)
                done_count <= done_count + 1;
            if (kind == KIND_FILL_REQ)
                fill_req_count <= fill_req_count + 1;
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result-side backpressure
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    task automatic send(op_t o, logic [31:0] a, logic [31:0] d);
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        addr <= a;
        wdata <= d;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_done(int target);
        in_valid <= 1'b0;
        do @(posedge clk); while (done_count < target);
    endtask

    task automatic single(op_t o, logic [31:0] a, logic [31:0] d);
        int target;
        target = done_count + 1;
        send(o, a, d);
        wait_done(target);
    endtask

    // read or write, then any fill words the miss asks for, optionally after one stray request
    task automatic access(op_t o, logic [31:0] a, logic [31:0] d, bit poke);
        int f0;
        int owed;
        int target;
        f0 = fill_req_count;
        single(o, a, d);
        owed = fill_req_count - f0;
        if (owed > 0)
        begin
            if (poke)
                single(op_t'($urandom_range(0, 2)), $urandom, $urandom);
            target = done_count + 1;
            for (int i = 0; i < owed; i++)
                send(OP_FILL, $urandom, $urandom);
            wait_done(target);
        end
    endtask

    function automatic logic [31:0] pick_addr();
        logic [25:0] t;
        case ($urandom_range(0, 9))
            0, 1, 2: t = 26'h0000000;
            3, 4, 5: t = 26'h3FFFFFF;
            6, 7:    t = 26'h1555555;
            default: t = 26'($urandom);
        endcase
        return {t, 6'($urandom)};
    endfunction

    task automatic set_latency(logic [15:0] hl, logic [15:0] ml);
        repeat (12) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HIT_LATENCY;
        cfg_data <= hl;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_MISS_LATENCY;
        cfg_data <= ml;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] hit_set[4];
        logic [15:0] miss_set[4];
        int r;
        hit_set = '{16'd1, 16'd65535, 16'd3, 16'd1};
        miss_set = '{16'd1, 16'd65535, 16'd200, 16'd65535};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_latency(16'd1, 16'd1);
        single(OP_FLUSH, 32'h0, 32'h0);
        single(OP_FILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        access(OP_WRITE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        access(OP_READ, 32'h0000_0003, 32'h0, 1'b0);
        access(OP_WRITE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        access(OP_READ, 32'hFFFF_FFFC, 32'h0, 1'b0);
        access(OP_WRITE, 32'hFFFF_FFF0, 32'hA5A5_5A5A, 1'b0);
        access(OP_WRITE, 32'h5555_5570, 32'h1234_5678, 1'b1);
        access(OP_READ, 32'hFFFF_FFF4, 32'h0, 1'b1);
        access(OP_WRITE, 32'h0000_0030, 32'hDEAD_BEEF, 1'b0);
        single(OP_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        access(OP_READ, 32'h0000_0000, 32'h0, 1'b0);

        for (int ph = 0; ph < 4; ph++)
        begin
            set_latency(hit_set[ph], miss_set[ph]);
            for (int i = 0; i < 12; i++)
            begin
                if (ph == 3 && i >= 6)
                    calm = 1'b1;
                r = $urandom_range(0, 29);
                if (r == 0)
                    single(OP_FLUSH, $urandom, $urandom);
                else if (r == 1)
                    single(OP_FILL, $urandom, $urandom);
                else
                    access(op_t'($urandom_range(0, 1)), pick_addr(), $urandom,
                           $urandom_range(0, 7) == 0);
            end
        end

        while (outstanding != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
